[hw/rtl/csv_tfp_pkg.sv]
// Shared types and constants of the CSV typed field parser.
`default_nettype none
package csv_tfp_pkg;

  // Widths fixed by the configuration registers and the result fields.
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 32;
  localparam int ColCountW = 5;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgColumnCount = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgColumnTypes = 1'd1;

  // Result kinds.
  localparam logic [2:0] KindInt     = 3'd0;
  localparam logic [2:0] KindDecimal = 3'd1;
  localparam logic [2:0] KindStrByte = 3'd2;
  localparam logic [2:0] KindStrEnd  = 3'd3;
  localparam logic [2:0] KindDiscard = 3'd4;

  // Column type codes.
  localparam logic [1:0] TypeInt     = 2'd0;
  localparam logic [1:0] TypeDecimal = 2'd1;

  // Characters.
  localparam logic [7:0] CharMinus   = 8'h2D;
  localparam logic [7:0] CharDot     = 8'h2E;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharComma   = 8'h2C;
  localparam logic [7:0] CharNewline = 8'h0A;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  column;
    logic [63:0] int_value;
    logic [63:0] frac_value;
    logic        negative;
    logic [7:0]  char_byte;
    logic        row_end;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

[hw/rtl/csv_tfp_core.sv]
// Input register, parse state and the per-byte field logic of the CSV parser.
`default_nettype none
module csv_tfp_core #(
  parameter int MAX_COLUMNS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [7:0]                          in_byte_i,
  input  wire logic                                in_end_i,
  input  wire logic [csv_tfp_pkg::ColCountW-1:0]   column_count_i,
  input  wire logic [csv_tfp_pkg::CfgDataW-1:0]    column_types_i,
  input  wire logic                                load_ok_i,
  output logic                                     load_o,
  output csv_tfp_pkg::res_t [2:0]                  res_o,
  output logic [1:0]                               res_cnt_o
);

  localparam int MaxCnt = (MAX_COLUMNS < 31) ? MAX_COLUMNS : 31;
  localparam int ColW = (MaxCnt > 1) ? $clog2(MaxCnt) : 1;
  localparam int CW = csv_tfp_pkg::ColCountW;

  logic       in_v_q;
  logic [7:0] in_b_q;
  logic       in_end_q;
  logic       fire;

  logic            hdr_q, hdr_d;
  logic [ColW-1:0] col_q, col_d;
  logic [63:0]     whole_q, whole_d;
  logic [63:0]     frac_q, frac_d;
  logic            sign_q, sign_d;
  logic            infrac_q, infrac_d;
  logic            fstart_q, fstart_d;

  logic [CW-1:0] cnt;
  logic [CW-1:0] col_raw;
  logic [CW-1:0] col_eff;
  logic [CW:0]   col_p1;
  logic [CW-1:0] col_next;
  logic [1:0]    col_type;
  logic          delim;
  logic          is_str;
  logic          emit_byte;
  logic          emit_field;
  logic          emit_discard;
  logic          row_end;
  logic [63:0]   digit;
  logic [63:0]   acc_src;
  logic [63:0]   acc_mac;
  csv_tfp_pkg::res_t r_byte, r_field, r_disc;
  csv_tfp_pkg::res_t [2:0] slots;

  assign fire       = in_v_q & load_ok_i;
  assign in_ready_o = ~in_v_q | fire;
  assign load_o     = fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_b_q   <= in_byte_i;
      in_end_q <= in_end_i;
    end
  end

  always_comb begin
    if (column_count_i == '0) begin
      cnt = CW'(1);
    end else if (int'(column_count_i) > MaxCnt) begin
      cnt = CW'(MaxCnt);
    end else begin
      cnt = column_count_i;
    end
  end

  assign col_raw  = CW'(col_q);
  assign col_eff  = (col_raw >= cnt) ? '0 : col_raw;
  assign col_p1   = {1'b0, col_eff} + (CW+1)'(1);
  assign row_end  = col_p1 >= {1'b0, cnt};
  assign col_next = row_end ? '0 : col_p1[CW-1:0];
  assign col_type = col_eff[4] ? csv_tfp_pkg::TypeInt
                               : column_types_i[{col_eff[3:0], 1'b0} +: 2];

  assign delim  = (in_b_q == csv_tfp_pkg::CharComma) || (in_b_q == csv_tfp_pkg::CharNewline);
  assign is_str = col_type[1];
  assign digit  = {56'b0, in_b_q} - {56'b0, csv_tfp_pkg::CharZero};
  assign acc_src = infrac_q ? frac_q : whole_q;
  assign acc_mac = (acc_src << 3) + (acc_src << 1) + digit;

  assign emit_byte    = ~hdr_q & ~delim & is_str;
  assign emit_field   = ~hdr_q & (delim | in_end_q);
  assign emit_discard = emit_field & in_end_q & (col_next != '0);

  // Accumulator and header state for this beat.
  always_comb begin
    hdr_d    = hdr_q;
    col_d    = col_q;
    whole_d  = whole_q;
    frac_d   = frac_q;
    sign_d   = sign_q;
    infrac_d = infrac_q;
    fstart_d = fstart_q;
    if (hdr_q) begin
      if (in_b_q == csv_tfp_pkg::CharNewline) begin
        hdr_d = 1'b0;
      end
    end else if (!delim) begin
      if (is_str) begin
        // String bytes go straight to the output.
      end else if (fstart_q && in_b_q == csv_tfp_pkg::CharMinus) begin
        sign_d = 1'b1;
      end else if (col_type == csv_tfp_pkg::TypeDecimal && !infrac_q &&
                   in_b_q == csv_tfp_pkg::CharDot) begin
        infrac_d = 1'b1;
      end else if (infrac_q) begin
        frac_d = acc_mac;
      end else begin
        whole_d = acc_mac;
      end
      fstart_d = 1'b0;
    end
  end

  always_comb begin
    r_byte           = '0;
    r_byte.kind      = csv_tfp_pkg::KindStrByte;
    r_byte.column    = col_eff[3:0];
    r_byte.char_byte = in_b_q;

    r_field         = '0;
    r_field.column  = col_eff[3:0];
    r_field.row_end = row_end;
    if (col_type == csv_tfp_pkg::TypeInt) begin
      r_field.kind      = csv_tfp_pkg::KindInt;
      r_field.int_value = sign_d ? (64'd0 - whole_d) : whole_d;
    end else if (col_type == csv_tfp_pkg::TypeDecimal) begin
      r_field.kind       = csv_tfp_pkg::KindDecimal;
      r_field.int_value  = whole_d;
      r_field.frac_value = frac_d;
      r_field.negative   = sign_d;
    end else begin
      r_field.kind = csv_tfp_pkg::KindStrEnd;
    end

    r_disc        = '0;
    r_disc.kind   = csv_tfp_pkg::KindDiscard;
    r_disc.column = col_next[3:0];
  end

  // Pack the results of this beat to the front and mark the final one.
  always_comb begin
    slots[0] = emit_byte ? r_byte : r_field;
    slots[1] = emit_byte ? r_field : r_disc;
    slots[2] = r_disc;
    res_cnt_o = 2'({1'b0, emit_byte} + {1'b0, emit_field} + {1'b0, emit_discard});
    for (int i = 0; i < 3; i++) begin
      slots[i].last = (res_cnt_o == 2'(i + 1));
    end
    res_o = slots;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q    <= 1'b1;
      col_q    <= '0;
      whole_q  <= '0;
      frac_q   <= '0;
      sign_q   <= 1'b0;
      infrac_q <= 1'b0;
      fstart_q <= 1'b1;
    end else if (fire) begin
      if (in_end_q) begin
        hdr_q    <= 1'b1;
        col_q    <= '0;
        whole_q  <= '0;
        frac_q   <= '0;
        sign_q   <= 1'b0;
        infrac_q <= 1'b0;
        fstart_q <= 1'b1;
      end else if (emit_field) begin
        hdr_q    <= hdr_d;
        col_q    <= ColW'(col_next);
        whole_q  <= '0;
        frac_q   <= '0;
        sign_q   <= 1'b0;
        infrac_q <= 1'b0;
        fstart_q <= 1'b1;
      end else begin
        hdr_q    <= hdr_d;
        col_q    <= col_d;
        whole_q  <= whole_d;
        frac_q   <= frac_d;
        sign_q   <= sign_d;
        infrac_q <= infrac_d;
        fstart_q <= fstart_d;
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/csv_tfp_outq.sv]
// Result register of the CSV parser: holds up to three results and sends one per beat.
`default_nettype none
module csv_tfp_outq (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    load_i,
  input  wire csv_tfp_pkg::res_t [2:0] res_i,
  input  wire logic [1:0]              res_cnt_i,
  output logic                         load_ok_o,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output csv_tfp_pkg::res_t            out_res_o
);

  csv_tfp_pkg::res_t [2:0] slot_q;
  logic [1:0]              cnt_q;
  logic                    pop;

  assign out_valid_o = cnt_q != 2'd0;
  assign pop         = out_valid_o & out_ready_i;
  assign load_ok_o   = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready_i);
  assign out_res_o   = slot_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= res_cnt_i;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= res_i;
    end else if (pop) begin
      slot_q[0] <= slot_q[1];
      slot_q[1] <= slot_q[2];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/csv_typed_field_parser_top.sv]
// Top level of the CSV typed field parser: configuration registers and stream ports.
`default_nettype none
// The parser takes one text byte per beat and reports typed fields. A byte
// goes through an input register, is parsed against the accumulators, and
// its results (none to three) land in a three-entry result register that
// sends one result per beat. Plain text, where each byte causes at most one
// result, streams at one byte per cycle while the output is ready; a byte
// that causes two or three results holds the input while the result register
// drains. The first line of every chunk is a header and is skipped, and the
// end of a chunk returns the parser to its reset state.
module csv_typed_field_parser_top #(
  parameter int MAX_COLUMNS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [csv_tfp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [csv_tfp_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [7:0]                        s_axis_tdata,  // data_byte
  input  wire logic                              s_axis_tlast,  // chunk_end
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // column, int_value, frac_value, negative, char_byte, row_end, zero fill
  output logic [143:0]                           m_axis_tdata,
  output logic [2:0]                             m_axis_tuser,  // kind
  output logic                                   m_axis_tlast   // last
);

  logic [csv_tfp_pkg::ColCountW-1:0] column_count_q;
  logic [csv_tfp_pkg::CfgDataW-1:0]  column_types_q;
  logic                              load;
  logic                              load_ok;
  logic [1:0]                        res_cnt;
  csv_tfp_pkg::res_t [2:0]           res;
  csv_tfp_pkg::res_t                 out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= csv_tfp_pkg::ColCountW'(1);
      column_types_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        csv_tfp_pkg::CfgColumnCount: begin
          column_count_q <= cfg_data_i[csv_tfp_pkg::ColCountW-1:0];
        end
        csv_tfp_pkg::CfgColumnTypes: begin
          column_types_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  csv_tfp_core #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_byte_i      (s_axis_tdata),
    .in_end_i       (s_axis_tlast),
    .column_count_i (column_count_q),
    .column_types_i (column_types_q),
    .load_ok_i      (load_ok),
    .load_o         (load),
    .res_o          (res),
    .res_cnt_o      (res_cnt)
  );

  csv_tfp_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .res_i       (res),
    .res_cnt_i   (res_cnt),
    .load_ok_o   (load_ok),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res)
  );

  assign m_axis_tdata = {2'b00, out_res.row_end, out_res.char_byte, out_res.negative,
                         out_res.frac_value, out_res.int_value, out_res.column};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule
`default_nettype wire
